/* sv/bds_pkg.sv */
package bds_pkg;

    localparam logic [1:0] MODE_OFF = 2'd0;
    localparam logic [1:0] MODE_2X  = 2'd1;
    localparam logic [1:0] MODE_3X  = 2'd2;

    localparam logic [1:0] REG_SCALE_MODE = 2'd0;
    localparam logic [1:0] REG_DST_WIDTH  = 2'd1;
    localparam logic [1:0] REG_DST_HEIGHT = 2'd2;

    localparam int          LANES         = 4;
    localparam int          LANE_W        = 12;
    localparam int          SUM_W         = LANES * LANE_W;
    localparam logic [28:0] RECIP_NINE    = 29'd477218588;
    localparam logic [12:0] MAX_DST_LINES = 13'd4096;
    localparam logic [11:0] LINE_LAST_MAX = 12'hfff;

    typedef struct packed {
        logic [1:0]  scale_mode;
        logic [10:0] dst_width;
        logic [12:0] dst_height;
    } cfg_t;

    typedef struct packed {
        logic [31:0] dst_pixel;
        logic        end_of_line;
        logic        end_of_frame;
    } res_t;

    function automatic logic [SUM_W-1:0] unpack_pixel(input logic [31:0] p);
        logic [SUM_W-1:0] r;
        r = '0;
        for (int k = 0; k < LANES; k++)
        begin
            r[k*LANE_W +: LANE_W] = {4'd0, p[k*8 +: 8]};
        end
        return r;
    endfunction

    function automatic logic [SUM_W-1:0] lane_add(input logic [SUM_W-1:0] a,
                                                  input logic [SUM_W-1:0] b);
        logic [SUM_W-1:0] r;
        r = '0;
        for (int k = 0; k < LANES; k++)
        begin
            r[k*LANE_W +: LANE_W] = a[k*LANE_W +: LANE_W] + b[k*LANE_W +: LANE_W];
        end
        return r;
    endfunction

    function automatic logic [31:0] average(input logic [SUM_W-1:0] sums,
                                            input logic             by_two);
        logic [31:0]       r;
        logic [LANE_W-1:0] s;
        logic [40:0]       prod;
        r = '0;
        for (int k = 0; k < LANES; k++)
        begin
            s    = sums[k*LANE_W +: LANE_W];
            prod = {29'd0, s} * {12'd0, RECIP_NINE};
            if (by_two)
            begin
                r[k*8 +: 8] = s[9:2];
            end
            else
            begin
                r[k*8 +: 8] = prod[39:32];
            end
        end
        return r;
    endfunction

endpackage

/* sv/bds_regs.sv */
module bds_regs
    import bds_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output cfg_t        cfg
);

    cfg_t cfg_reg;
    logic wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.scale_mode <= MODE_OFF;
            cfg_reg.dst_width  <= 11'd1;
            cfg_reg.dst_height <= 13'd1;
        end
        else if (wr_en)
        begin
            case (paddr[3:2])
                REG_SCALE_MODE: cfg_reg.scale_mode <= pwdata[1:0];
                REG_DST_WIDTH:  cfg_reg.dst_width  <= pwdata[10:0];
                REG_DST_HEIGHT: cfg_reg.dst_height <= pwdata[12:0];
                default:        cfg_reg <= cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_SCALE_MODE: prdata = {30'd0, cfg_reg.scale_mode};
            REG_DST_WIDTH:  prdata = {21'd0, cfg_reg.dst_width};
            REG_DST_HEIGHT: prdata = {19'd0, cfg_reg.dst_height};
            default:        prdata = 32'd0;
        endcase
    end

endmodule

/* sv/bds_accum.sv */
module bds_accum
    import bds_pkg::*;
#(
    parameter int MAX_DST_WIDTH = 1024
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  cfg_t        cfg,
    input  logic        in_accept,
    input  logic [31:0] in_pixel,
    output logic        push,
    output res_t        push_res
);

    localparam int CW = (MAX_DST_WIDTH > 1) ? $clog2(MAX_DST_WIDTH) : 1;

    logic [SUM_W-1:0] col_mem [MAX_DST_WIDTH];
    logic [SUM_W-1:0] rd_reg;
    logic [SUM_W-1:0] brs_reg;
    logic [1:0]       col_phase_reg;
    logic [1:0]       row_phase_reg;
    logic [CW-1:0]    out_column_reg;
    logic [11:0]      out_line_reg;

    logic             active;
    logic             step;
    logic             col_end;
    logic             row_end;
    logic             col_last;
    logic             line_last;
    logic [12:0]      w_last;
    logic [11:0]      h_last;
    logic [SUM_W-1:0] pix;
    logic [SUM_W-1:0] brs_next;
    logic [SUM_W-1:0] csum;

    assign active = (cfg.scale_mode == MODE_2X) || (cfg.scale_mode == MODE_3X);
    assign step   = in_accept & active;

    always_comb
    begin
        if (cfg.dst_width == 11'd0)
        begin
            w_last = 13'd0;
        end
        else if ({2'd0, cfg.dst_width} > 13'(MAX_DST_WIDTH))
        begin
            w_last = 13'(MAX_DST_WIDTH - 1);
        end
        else
        begin
            w_last = {2'd0, cfg.dst_width} - 13'd1;
        end

        if (cfg.dst_height == 13'd0)
        begin
            h_last = 12'd0;
        end
        else if (cfg.dst_height > MAX_DST_LINES)
        begin
            h_last = LINE_LAST_MAX;
        end
        else
        begin
            h_last = 12'(cfg.dst_height - 13'd1);
        end
    end

    assign col_end   = col_phase_reg >= cfg.scale_mode;
    assign row_end   = row_phase_reg >= cfg.scale_mode;
    assign col_last  = 13'(out_column_reg) >= w_last;
    assign line_last = out_line_reg >= h_last;

    assign pix      = unpack_pixel(in_pixel);
    assign brs_next = (col_phase_reg == 2'd0) ? pix : lane_add(brs_reg, pix);
    assign csum     = (row_phase_reg == 2'd0) ? brs_next : lane_add(rd_reg, brs_next);

    assign push                  = step & col_end & row_end;
    assign push_res.dst_pixel    = average(csum, cfg.scale_mode == MODE_2X);
    assign push_res.end_of_line  = col_last;
    assign push_res.end_of_frame = col_last & line_last;

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            brs_reg <= brs_next;
            if (col_phase_reg == 2'd0)
            begin
                rd_reg <= col_mem[out_column_reg];
            end
            if (col_end)
            begin
                col_mem[out_column_reg] <= csum;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_phase_reg  <= 2'd0;
            row_phase_reg  <= 2'd0;
            out_column_reg <= '0;
            out_line_reg   <= 12'd0;
        end
        else if (step)
        begin
            if (!col_end)
            begin
                col_phase_reg <= col_phase_reg + 2'd1;
            end
            else
            begin
                col_phase_reg <= 2'd0;
                if (col_last)
                begin
                    out_column_reg <= '0;
                    if (row_end)
                    begin
                        row_phase_reg <= 2'd0;
                        out_line_reg  <= line_last ? 12'd0 : out_line_reg + 12'd1;
                    end
                    else
                    begin
                        row_phase_reg <= row_phase_reg + 2'd1;
                    end
                end
                else
                begin
                    out_column_reg <= out_column_reg + CW'(1);
                end
            end
        end
    end

endmodule

/* sv/bds_out_buf.sv */
module bds_out_buf
    import bds_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  res_t push_res,
    output logic push_ready,
    output logic out_valid,
    input  logic out_ready,
    output res_t out_res
);

    res_t main_reg;
    res_t skid_reg;
    logic main_valid_reg;
    logic skid_valid_reg;
    logic load;

    assign push_ready = ~skid_valid_reg;
    assign out_valid  = main_valid_reg;
    assign out_res    = main_reg;
    assign load       = ~main_valid_reg | out_ready;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            main_reg <= skid_valid_reg ? skid_reg : push_res;
        end
        else if (push)
        begin
            skid_reg <= push_res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (load)
        begin
            main_valid_reg <= skid_valid_reg | push;
            skid_valid_reg <= 1'b0;
        end
        else if (push)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

endmodule

/* sv/box_downscale_2x_3x_core.sv */
// Box-filter downscaler, 2x2 or 3x3, for a raster stream of ARGB pixels.
// Slave stream: one source pixel per word on s_tdata, raster order.
// Master stream: one averaged pixel per word on m_tdata; m_tlast marks the
// last pixel of an output line, m_tuser the last pixel of the frame.
// APB port: scale_mode at 0x0 (0 off, 1 by two, 2 by three), dst_width at
// 0x4, dst_height at 0x8; write only while the stream is idle.
// Throughput: one source word per cycle while the output buffer has room. Each
// word is summed in the accepting cycle; a block's column sum is read from the
// line store at the first word of each of its rows and written back by the
// last word of each row. A block's result is formed from its last source word
// and registered into the output buffer, which drives m_tvalid.
// A two-entry output buffer decouples the sides: s_tready drops only when
// both entries hold words, so a stalled receiver stops the source after two
// pending results. In modes 0 and 3 source words are consumed and dropped.
// Reset clears the registers, phases and counters; the line store is not
// cleared, since every entry is written by the first row of a block group.
module box_downscale_2x_3x_core
    import bds_pkg::*;
#(
    parameter int MAX_DST_WIDTH = 1024
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // src_pixel [31:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // dst_pixel [31:0]
    output logic        m_tlast,
    output logic        m_tuser,   // end_of_frame [0]
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    cfg_t cfg;
    res_t push_res;
    res_t out_res;
    logic push;
    logic in_accept;

    assign in_accept = s_tvalid & s_tready;

    bds_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    bds_accum #(
        .MAX_DST_WIDTH (MAX_DST_WIDTH)
    ) u_accum (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_accept (in_accept),
        .in_pixel  (s_tdata),
        .push      (push),
        .push_res  (push_res)
    );

    bds_out_buf u_out_buf (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_res   (push_res),
        .push_ready (s_tready),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_res    (out_res)
    );

    assign m_tdata = out_res.dst_pixel;
    assign m_tlast = out_res.end_of_line;
    assign m_tuser = out_res.end_of_frame;

endmodule

/* verif/box_downscale_2x_3x_core_test.sv */
`timescale 1ns / 1ps

module box_downscale_2x_3x_core_test
    import bds_pkg::*;
;

    localparam logic [1:0] MODE_SPARE = 2'd3;
    localparam int         STORE_SIZE = 1024;
    localparam int         LINES_MAX  = 4096;

    class downscale_board;
        logic [1:0]       mode;
        logic [10:0]      width;
        logic [12:0]      height;
        logic [3:0][11:0] col_sums [STORE_SIZE];
        logic [3:0][11:0] row_sum;
        int unsigned      col_ph;
        int unsigned      row_ph;
        int unsigned      out_col;
        int unsigned      out_line;
        res_t             due_pixels [$];
        int               errors;

        function new();
            mode     = MODE_OFF;
            width    = 11'd1;
            height   = 13'd1;
            row_sum  = '0;
            col_ph   = 0;
            row_ph   = 0;
            out_col  = 0;
            out_line = 0;
            errors   = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [31:0] value);
            case (idx)
                REG_SCALE_MODE: mode   = value[1:0];
                REG_DST_WIDTH:  width  = value[10:0];
                REG_DST_HEIGHT: height = value[12:0];
                default: ;
            endcase
        endfunction

        function void take_pixel(logic [31:0] pix);
            int unsigned      last;
            int unsigned      w;
            int unsigned      h;
            int unsigned      idx;
            int               k;
            logic [3:0][11:0] acc;
            logic [63:0]      prod;
            res_t             r;
            if (mode != MODE_2X && mode != MODE_3X)
            begin
                return;
            end
            last = (mode == MODE_2X) ? 1 : 2;
            w = (width == 0) ? 1 : ((width > STORE_SIZE) ? STORE_SIZE : width);
            h = (height == 0) ? 1 : ((height > LINES_MAX) ? LINES_MAX : height);
            for (k = 0; k < 4; k++)
            begin
                row_sum[k] = ((col_ph == 0) ? 12'd0 : row_sum[k]) + {4'd0, pix[8*k +: 8]};
            end
            if (col_ph < last)
            begin
                col_ph++;
                return;
            end
            col_ph = 0;
            idx = (out_col < STORE_SIZE) ? out_col : STORE_SIZE - 1;
            for (k = 0; k < 4; k++)
            begin
                col_sums[idx][k] = ((row_ph == 0) ? 12'd0 : col_sums[idx][k]) + row_sum[k];
            end
            if (row_ph >= last)
            begin
                acc = col_sums[idx];
                for (k = 0; k < 4; k++)
                begin
                    prod = {52'd0, acc[k]} * 64'd477218588;
                    r.dst_pixel[8*k +: 8] = (mode == MODE_2X) ? acc[k][9:2] : prod[39:32];
                end
                r.end_of_line  = (out_col >= w - 1);
                r.end_of_frame = r.end_of_line && (out_line >= h - 1);
                due_pixels.push_back(r);
            end
            if (out_col >= w - 1)
            begin
                out_col = 0;
                if (row_ph >= last)
                begin
                    row_ph   = 0;
                    out_line = (out_line >= h - 1) ? 0 : out_line + 1;
                end
                else
                begin
                    row_ph++;
                end
            end
            else
            begin
                out_col++;
            end
        endfunction

        function void check_result(logic [31:0] pix, logic eol, logic eof);
            res_t want;
            if (due_pixels.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected word: expected none, got pixel %h eol %b eof %b",
                         $time, pix, eol, eof);
                return;
            end
            want = due_pixels.pop_front();
            if (want.dst_pixel !== pix)
            begin
                errors++;
                $display("%0t: dst_pixel: expected %h, got %h", $time, want.dst_pixel, pix);
            end
            if (want.end_of_line !== eol)
            begin
                errors++;
                $display("%0t: end_of_line: expected %b, got %b", $time, want.end_of_line, eol);
            end
            if (want.end_of_frame !== eof)
            begin
                errors++;
                $display("%0t: end_of_frame: expected %b, got %b",
                         $time, want.end_of_frame, eof);
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic        m_tlast;
    logic        m_tuser;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    downscale_board board = new();
    int             gap_pct   = 0;
    int             stall_pct = 0;
    int             hold_left = 0;

    box_downscale_2x_3x_core i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            board.check_result(m_tdata, m_tlast, m_tuser);
        end
        if (hold_left > 0)
        begin
            m_tready <= 1'b0;
            hold_left--;
        end
        else
        begin
            m_tready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    function automatic logic [31:0] rand_pixel();
        case ($urandom_range(0, 15))
            0:       return 32'hffffffff;
            1:       return 32'h00000000;
            default: return $urandom;
        endcase
    endfunction

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
        begin
            @(posedge clk);
        end
        board.set_reg(idx, value);
        // read back with a back-to-back transfer
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(negedge clk);
        while (!pready)
        begin
            @(negedge clk);
        end
        if (prdata !== value)
        begin
            board.errors++;
            $display("%0t: register %0d: expected %h, got %h", $time, idx, value, prdata);
        end
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_pixel(input logic [31:0] pix);
        int gap;
        gap = 0;
        while (gap < 30 && $urandom_range(0, 99) < gap_pct)
        begin
            gap++;
        end
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= pix;
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
        board.take_pixel(pix);
    endtask

    task automatic send_same(input logic [31:0] pix, input int count);
        repeat (count) send_pixel(pix);
    endtask

    task automatic send_random(input int count);
        repeat (count) send_pixel(rand_pixel());
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (board.due_pixels.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic configure(input logic [1:0] mode, input logic [10:0] w,
                             input logic [12:0] h);
        // a new width is safe only at the start of a block group
        while (board.row_ph != 0)
        begin
            send_pixel(rand_pixel());
        end
        drain();
        write_reg(REG_SCALE_MODE, {30'd0, mode});
        write_reg(REG_DST_WIDTH, {21'd0, w});
        write_reg(REG_DST_HEIGHT, {19'd0, h});
    endtask

    initial
    begin
        logic [1:0]  mode;
        logic [10:0] w;
        logic [12:0] h;
        int          p;
        rst_n    = 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // off after reset: words are dropped
        send_pixel(32'hffffffff);
        send_pixel(32'h00000000);
        drain();
        write_reg(REG_SCALE_MODE, {30'd0, MODE_2X});
        send_same(32'hffffffff, 4);
        send_same(32'h00000000, 4);
        drain();
        // full-scale sums are multiples of nine
        write_reg(REG_SCALE_MODE, {30'd0, MODE_3X});
        send_same(32'hffffffff, 9);
        drain();
        write_reg(REG_SCALE_MODE, {30'd0, MODE_SPARE});
        send_pixel(32'h12345678);
        send_pixel(32'hedcba987);
        drain();
        // shrink the width in the middle of the first row
        configure(MODE_2X, 11'd2, 13'd2);
        send_random(3);
        drain();
        write_reg(REG_DST_WIDTH, 32'd1);
        send_random(3);

        for (p = 0; p < 8; p++)
        begin
            case (p)
                0:
                begin
                    mode = MODE_2X;
                    w    = 11'd3;
                    h    = 13'd2;
                end
                1:
                begin
                    mode = MODE_2X;
                    w    = 11'd2047;
                    h    = 13'd4096;
                end
                2:
                begin
                    mode = MODE_2X;
                    w    = 11'd0;
                    h    = 13'd8191;
                end
                3:
                begin
                    mode = MODE_3X;
                    w    = 11'd1024;
                    h    = 13'd0;
                end
                default:
                begin
                    case ($urandom_range(0, 9))
                        0:       mode = MODE_OFF;
                        1:       mode = MODE_SPARE;
                        2, 3, 4: mode = MODE_2X;
                        default: mode = MODE_3X;
                    endcase
                    w = ($urandom_range(0, 9) == 0) ? 11'd0 : 11'($urandom_range(1, 6));
                    h = ($urandom_range(0, 9) == 0) ? 13'd0 : 13'($urandom_range(1, 4));
                end
            endcase
            configure(mode, w, h);
            case (p % 4)
                0:
                begin
                    gap_pct   = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    gap_pct   = 83;
                    stall_pct = 0;
                end
                2:
                begin
                    gap_pct   = 0;
                    stall_pct = 83;
                end
                default:
                begin
                    gap_pct   = 9;
                    stall_pct = 9;
                end
            endcase
            if (p == 0)
            begin
                hold_left = 300;
            end
            send_random(85);
        end

        drain();
        if (board.errors == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("simulation failed");
        end
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule
